[hdl/bxiir_pkg.sv]
// ----------------------------------------------------------------------------
// bxiir_pkg
// Shared widths, register codes and the result record for the boxcar average
// and shift-based first-order filter.
// ----------------------------------------------------------------------------
package bxiir_pkg;

	// Result and register widths
	localparam int OUT_W      = 13;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int OFFSET_W   = 12;
	localparam int SHIFT_W    = 4;
	localparam int ACC_W      = 32;
	localparam int FOUT_W     = 16;

	// Output queue sizing
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_PTR_W = 2;
	localparam int OUTQ_CNT_W = 3;

	// Reset value of the filter shift register
	localparam logic [SHIFT_W-1:0] FILTER_SHIFT_RST = 4'd4;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_ADD   = 1'b0,
		REG_FILTER_SHIFT = 1'b1
	} cfg_reg_t;

	// One finished result on its way into the output queue
	typedef struct packed {
		logic             valid;
		logic [OUT_W-1:0] window_average;
		logic [OUT_W-1:0] filtered_value;
	} result_t;

endpackage

[hdl/boxcar_average_then_shift_iir.sv]
// ----------------------------------------------------------------------------
// boxcar_average_then_shift_iir
// Boxcar window average of converter samples followed by a shift-based
// first-order low-pass filter.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid/in_ready with the sample field; each accepted
//   transaction produces exactly one result on out_valid/out_ready carrying
//   window_average and filtered_value.
//   Throughput: one transaction per cycle, sustained while the receiver takes
//   results; the ring memory writes the new sample and reads the oldest one
//   in the same cycle through separate ports.
//   Path: a result passes the ring read, the window sum and the filter
//   update into the output queue, in that order, before it is offered.
//   Stall: a four-entry output queue holds results while out_ready is low;
//   in_ready drops once queued plus in-flight results reach four, so nothing
//   is lost.
//   Reset: position, window sum, filter state and queue clear at once; the
//   ring is not swept, entries not yet written since reset read as zero
//   through a first-wrap flag, so samples are taken right after reset.
//   Configuration: cfg_we with cfg_index/cfg_data writes offset_add (index 0)
//   or filter_shift (index 1, reset 4); write only while idle.
// ----------------------------------------------------------------------------
module boxcar_average_then_shift_iir
	import bxiir_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32768,
	parameter int SAMPLE_BITS  = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sample,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_W-1:0]       window_average,
	output logic [OUT_W-1:0]       filtered_value
);

	localparam int AVG_W = ((SAMPLE_BITS + 1 > OFFSET_W) ? SAMPLE_BITS + 1 : OFFSET_W) + 1;

	logic [OFFSET_W-1:0]   offset_q;
	logic [SHIFT_W-1:0]    shift_q;
	logic                  in_accept;
	logic                  busy_s1;
	logic                  avg_valid;
	logic [AVG_W-1:0]      avg;
	result_t               res;
	logic [OUTQ_CNT_W-1:0] q_count;
	logic [OUTQ_CNT_W-1:0] pending;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			shift_q  <= FILTER_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OFFSET_ADD:   offset_q <= cfg_data[OFFSET_W-1:0];
				REG_FILTER_SHIFT: shift_q  <= cfg_data[SHIFT_W-1:0];
				default:          ;
			endcase
		end
	end

	// Reserve queue space for every transaction in flight
	assign pending   = q_count + OUTQ_CNT_W'(busy_s1) + OUTQ_CNT_W'(avg_valid);
	assign in_ready  = (pending < OUTQ_CNT_W'(OUTQ_DEPTH));
	assign in_accept = in_valid && in_ready;

	bxiir_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.AVG_W        (AVG_W)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.sample     (sample),
		.offset_add (offset_q),
		.busy_s1    (busy_s1),
		.avg_valid  (avg_valid),
		.avg        (avg)
	);

	bxiir_filter #(
		.AVG_W (AVG_W)
	) u_filter (
		.clk          (clk),
		.arst_n       (arst_n),
		.avg_valid    (avg_valid),
		.avg          (avg),
		.filter_shift (shift_q),
		.res          (res)
	);

	bxiir_outq u_outq (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (res),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.window_average (window_average),
		.filtered_value (filtered_value),
		.count          (q_count)
	);

endmodule

[hdl/bxiir_window.sv]
// ----------------------------------------------------------------------------
// bxiir_window
// Sample ring memory and running window sum. Writes each sample at the write
// position, reads the oldest entry at the next position, and forms the
// shifted window average plus offset one stage later.
// ----------------------------------------------------------------------------
module bxiir_window
	import bxiir_pkg::*;
#(
	parameter int WINDOW_DEPTH = 32768,
	parameter int SAMPLE_BITS  = 12,
	parameter int AVG_W        = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_accept,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [OFFSET_W-1:0]    offset_add,
	output logic                   busy_s1,
	output logic                   avg_valid,
	output logic [AVG_W-1:0]       avg
);

	localparam int POS_W     = $clog2(WINDOW_DEPTH);
	localparam int SUM_W     = SAMPLE_BITS + POS_W;
	localparam int AVG_SHIFT = $clog2(WINDOW_DEPTH + 1) - 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_DEPTH - 1);

	logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];

	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       pos_next;
	logic                   wrapped_q;
	logic                   old_ok;

	logic                   v_s1;
	logic                   old_ok_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [SAMPLE_BITS-1:0] rd_s1;

	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       sum_next;
	logic [SAMPLE_BITS-1:0] oldest;

	logic                   v_s2;
	logic [AVG_W-1:0]       avg_s2;

	// Next write position; the entry there is the oldest sample
	assign pos_next = (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);

	// Entries past the write position hold nothing until the first wrap
	assign old_ok = wrapped_q || (pos_q == LAST_POS);

	// Write the new sample, read the oldest one
	always_ff @(posedge clk) begin
		if (in_accept) begin
			ring[pos_q] <= sample;
			rd_s1       <= ring[pos_next];
			sample_s1   <= sample;
		end
	end

	// Advance the write position and track the first wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			v_s1      <= 1'b0;
			old_ok_s1 <= 1'b0;
		end else begin
			v_s1 <= in_accept;
			if (in_accept) begin
				pos_q     <= pos_next;
				old_ok_s1 <= old_ok;
				if (pos_q == LAST_POS) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// Add the new sample and drop the oldest
	assign oldest   = old_ok_s1 ? rd_s1 : '0;
	assign sum_next = sum_q + SUM_W'(sample_s1) - SUM_W'(oldest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			if (v_s1) begin
				sum_q <= sum_next;
			end
		end
	end

	// Shift the window sum down and add the offset
	always_ff @(posedge clk) begin
		if (v_s1) begin
			avg_s2 <= AVG_W'(sum_next >> AVG_SHIFT) + AVG_W'(offset_add);
		end
	end

	assign busy_s1   = v_s1;
	assign avg_valid = v_s2;
	assign avg       = avg_s2;

endmodule

[hdl/bxiir_filter.sv]
// ----------------------------------------------------------------------------
// bxiir_filter
// Shift-based first-order filter: the accumulator grows by the average minus
// the last output, and the new output is the accumulator shifted right.
// ----------------------------------------------------------------------------
module bxiir_filter
	import bxiir_pkg::*;
#(
	parameter int AVG_W = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               avg_valid,
	input  logic [AVG_W-1:0]   avg,
	input  logic [SHIFT_W-1:0] filter_shift,
	output result_t            res
);

	logic        [ACC_W-1:0]  acc_q;
	logic        [FOUT_W-1:0] fout_q;
	logic        [ACC_W-1:0]  acc_next;
	logic signed [ACC_W-1:0]  acc_shifted;
	logic        [FOUT_W-1:0] fout_next;

	// Accumulate the average minus the sign-extended previous output
	assign acc_next = acc_q + ACC_W'(avg)
		- {{(ACC_W - FOUT_W){fout_q[FOUT_W-1]}}, fout_q};

	// Arithmetic shift, keep the low output bits
	assign acc_shifted = $signed(acc_next) >>> filter_shift;
	assign fout_next   = acc_shifted[FOUT_W-1:0];

	// Hold filter state between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fout_q <= '0;
		end else if (avg_valid) begin
			acc_q  <= acc_next;
			fout_q <= fout_next;
		end
	end

	// Hand the finished result to the output queue
	assign res.valid          = avg_valid;
	assign res.window_average = avg[OUT_W-1:0];
	assign res.filtered_value = fout_next[OUT_W-1:0];

endmodule

[hdl/bxiir_outq.sv]
// ----------------------------------------------------------------------------
// bxiir_outq
// Small result queue that decouples the filter pipeline from the receiver.
// Space is reserved upstream, so a push always finds a free entry.
// ----------------------------------------------------------------------------
module bxiir_outq
	import bxiir_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  result_t               push,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_W-1:0]      window_average,
	output logic [OUT_W-1:0]      filtered_value,
	output logic [OUTQ_CNT_W-1:0] count
);

	logic [OUT_W-1:0]      avg_mem  [OUTQ_DEPTH];
	logic [OUT_W-1:0]      filt_mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0] head_q;
	logic [OUTQ_PTR_W-1:0] tail_q;
	logic [OUTQ_CNT_W-1:0] count_q;
	logic                  pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push.valid) begin
			avg_mem[tail_q]  <= push.window_average;
			filt_mem[tail_q] <= push.filtered_value;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				tail_q <= tail_q + OUTQ_PTR_W'(1);
			end
			if (pop) begin
				head_q <= head_q + OUTQ_PTR_W'(1);
			end
			case ({push.valid, pop})
				2'b10:   count_q <= count_q + OUTQ_CNT_W'(1);
				2'b01:   count_q <= count_q - OUTQ_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign window_average = avg_mem[head_q];
	assign filtered_value = filt_mem[head_q];
	assign count          = count_q;

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (count_q < OUTQ_CNT_W'(OUTQ_DEPTH)))
		else $error("result pushed into a full queue");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push.valid) |=> (count_q == $past(count_q) - OUTQ_CNT_W'(1)))
		else $error("queue occupancy did not drop on a lone pop");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> out_valid)
		else $error("pushed result not offered at the output");
`endif

endmodule
